@@ rtl/wtsa_pkg.sv @@
// shared constants, codes and types of the windowed time series aggregator
`timescale 1ns / 1ps
package wtsa_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   localparam int TIME_WIDTH      = 64;
   localparam int RESULT_WIDTH    = 64;
   localparam int METHOD_WIDTH    = 3;
   localparam int INTERVAL_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int QUEUE_DEPTH     = 4;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_METHOD   = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTERVAL = 1'd1;

   // aggregation codes
   localparam logic [METHOD_WIDTH-1:0] METHOD_PASS = 3'd0;
   localparam logic [METHOD_WIDTH-1:0] METHOD_AVG  = 3'd1;
   localparam logic [METHOD_WIDTH-1:0] METHOD_SUM  = 3'd2;
   localparam logic [METHOD_WIDTH-1:0] METHOD_MIN  = 3'd3;
   localparam logic [METHOD_WIDTH-1:0] METHOD_MAX  = 3'd4;

   typedef struct packed {
      logic [METHOD_WIDTH-1:0]   method;
      logic [INTERVAL_WIDTH-1:0] interval;
   } cfg_type;

endpackage

@@ rtl/wtsa_if.sv @@
// channel interfaces: sample input, result output and register write port
`timescale 1ns / 1ps
interface wtsa_req_if
   import wtsa_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic [TIME_WIDTH-1:0]         sample_time;
   logic signed [VALUE_WIDTH-1:0] sample_value;
   logic                          end_of_stream;

   modport source (output valid, sample_time, sample_value, end_of_stream, input ready);
   modport sink (input valid, sample_time, sample_value, end_of_stream, output ready);
endinterface

interface wtsa_rsp_if
   import wtsa_pkg::*;
;
   logic                           valid;
   logic                           ready;
   logic [TIME_WIDTH-1:0]          window_time;
   logic signed [RESULT_WIDTH-1:0] window_value;
   logic                           stream_done;

   modport source (output valid, window_time, window_value, stream_done, input ready);
   modport sink (input valid, window_time, window_value, stream_done, output ready);
endinterface

interface wtsa_csr_if
   import wtsa_pkg::*;
;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/wtsa_front.sv @@
// front part: accepts samples, keeps the window accumulators, queues result jobs
`timescale 1ns / 1ps
module wtsa_front
   import wtsa_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT,
   parameter int JOB_WIDTH   = TIME_WIDTH + RESULT_WIDTH + COUNT_WIDTH + 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [TIME_WIDTH-1:0]         in_time,
   input  logic signed [VALUE_WIDTH-1:0] in_value,
   input  logic                          in_last,
   output logic                          push,
   output logic [JOB_WIDTH-1:0]          push_job,
   input  logic                          q_full
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic signed [RESULT_WIDTH-1:0] SUM_MAX = {1'b0, {(RESULT_WIDTH-1){1'b1}}};
   localparam logic signed [RESULT_WIDTH-1:0] SUM_MIN = {1'b1, {(RESULT_WIDTH-1){1'b0}}};

   logic                           open_ff;
   logic [TIME_WIDTH-1:0]          start_ff;
   logic signed [RESULT_WIDTH-1:0] sum_ff;
   logic [COUNT_WIDTH-1:0]         count_ff;
   logic signed [VALUE_WIDTH-1:0]  min_ff;
   logic signed [VALUE_WIDTH-1:0]  max_ff;
   logic                           pend_valid_ff;
   logic [JOB_WIDTH-1:0]           pend_job_ff;

   logic signed [RESULT_WIDTH-1:0] value_ext;
   logic                           is_pass;
   logic [TIME_WIDTH-1:0]          elapsed;
   logic                           close;
   logic                           restart;
   logic signed [RESULT_WIDTH-1:0] sum_add;
   logic                           sum_ovf;
   logic signed [RESULT_WIDTH-1:0] sum_sat;
   logic [TIME_WIDTH-1:0]          start_in;
   logic signed [RESULT_WIDTH-1:0] sum_in;
   logic [COUNT_WIDTH-1:0]         count_in;
   logic signed [VALUE_WIDTH-1:0]  min_in;
   logic signed [VALUE_WIDTH-1:0]  max_in;
   logic [JOB_WIDTH-1:0]           job_close;
   logic [JOB_WIDTH-1:0]           job_flush;
   logic [JOB_WIDTH-1:0]           job_pass;
   logic [JOB_WIDTH-1:0]           job_a;
   logic                           has_a;
   logic                           has_b;
   logic                           accept;

   // job layout: time, value, count, divide flag, last flag
   function automatic logic [JOB_WIDTH-1:0] make_job(
      input logic [METHOD_WIDTH-1:0]        method,
      input logic [TIME_WIDTH-1:0]          t,
      input logic signed [RESULT_WIDTH-1:0] sum,
      input logic [COUNT_WIDTH-1:0]         cnt,
      input logic signed [VALUE_WIDTH-1:0]  mn,
      input logic signed [VALUE_WIDTH-1:0]  mx,
      input logic                           done
   );
      logic signed [RESULT_WIDTH-1:0] v;
      logic                           dv;
      dv = 1'b0;
      unique case (method)
         METHOD_AVG: begin
            v  = sum;
            dv = 1'b1;
         end
         METHOD_SUM: v = sum;
         METHOD_MIN: v = RESULT_WIDTH'(mn);
         default:    v = RESULT_WIDTH'(mx);
      endcase
      return {t, v, cnt, dv, done};
   endfunction

   assign value_ext = RESULT_WIDTH'(in_value);
   assign is_pass   = (cfg.method == METHOD_PASS) || (cfg.method > METHOD_MAX);
   assign elapsed   = in_time - start_ff;
   assign close     = open_ff && (cfg.interval != '0) &&
                      (elapsed >= TIME_WIDTH'(cfg.interval));
   assign restart   = !open_ff || close;

   // saturating sum
   assign sum_add = sum_ff + value_ext;
   assign sum_ovf = (sum_ff[RESULT_WIDTH-1] == value_ext[RESULT_WIDTH-1]) &&
                    (sum_add[RESULT_WIDTH-1] != sum_ff[RESULT_WIDTH-1]);
   assign sum_sat = sum_ovf ? (value_ext[RESULT_WIDTH-1] ? SUM_MIN : SUM_MAX) : sum_add;

   always_comb begin
      if (restart) begin
         start_in = in_time;
         sum_in   = value_ext;
         count_in = COUNT_WIDTH'(1);
         min_in   = in_value;
         max_in   = in_value;
      end else begin
         start_in = start_ff;
         sum_in   = sum_sat;
         count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_WIDTH'(1);
         min_in   = (in_value < min_ff) ? in_value : min_ff;
         max_in   = (in_value > max_ff) ? in_value : max_ff;
      end
   end

   assign job_close = make_job(cfg.method, start_ff, sum_ff, count_ff, min_ff, max_ff, 1'b0);
   assign job_flush = make_job(cfg.method, start_in, sum_in, count_in, min_in, max_in, 1'b1);
   assign job_pass  = {in_time, value_ext, {COUNT_WIDTH{1'b0}}, 1'b0, in_last};

   always_comb begin
      if (is_pass) begin
         job_a = job_pass;
         has_a = 1'b1;
         has_b = 1'b0;
      end else if (close) begin
         job_a = job_close;
         has_a = 1'b1;
         has_b = in_last;
      end else begin
         job_a = job_flush;
         has_a = in_last;
         has_b = 1'b0;
      end
   end

   // the second job of a closing last sample waits in the pending register until the queue has room
   assign in_ready = !pend_valid_ff && !q_full;
   assign accept   = in_valid && in_ready;
   assign push     = pend_valid_ff ? !q_full : (accept && has_a);
   assign push_job = pend_valid_ff ? pend_job_ff : job_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         start_ff      <= '0;
         sum_ff        <= '0;
         count_ff      <= '0;
         min_ff        <= '0;
         max_ff        <= '0;
      end else begin
         if (pend_valid_ff && !q_full) begin
            pend_valid_ff <= 1'b0;
         end
         if (accept) begin
            if (is_pass) begin
               if (in_last) begin
                  open_ff <= 1'b0;
               end
            end else begin
               open_ff  <= !in_last;
               start_ff <= start_in;
               sum_ff   <= sum_in;
               count_ff <= count_in;
               min_ff   <= min_in;
               max_ff   <= max_in;
            end
            if (has_b) begin
               pend_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && has_b) begin
         pend_job_ff <= job_flush;
      end
   end

endmodule

@@ rtl/wtsa_fifo.sv @@
// short job queue between the front and back parts
`timescale 1ns / 1ps
module wtsa_fifo
   import wtsa_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             pop_valid
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(DEPTH - 1);

   logic [WIDTH-1:0]     mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff;
   logic [PTR_WIDTH-1:0] rd_ptr_ff;
   logic [CNT_WIDTH-1:0] cnt_ff;
   logic                 do_push;
   logic                 do_pop;

   assign full      = (cnt_ff == CNT_WIDTH'(DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + CNT_WIDTH'(1);
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - CNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/wtsa_back.sv @@
// back part: finishes result jobs, runs the average divider, holds the output register
`timescale 1ns / 1ps
module wtsa_back
   import wtsa_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT,
   parameter int JOB_WIDTH   = TIME_WIDTH + RESULT_WIDTH + COUNT_WIDTH + 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           job_valid,
   input  logic [JOB_WIDTH-1:0]           job,
   output logic                           pop,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [TIME_WIDTH-1:0]          out_time,
   output logic signed [RESULT_WIDTH-1:0] out_value,
   output logic                           out_done
);

   localparam int STEP_WIDTH = $clog2(RESULT_WIDTH);
   localparam logic [STEP_WIDTH-1:0] STEP_LAST = STEP_WIDTH'(RESULT_WIDTH - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]                     state_ff;
   logic [1:0]                     state_in;
   logic [STEP_WIDTH-1:0]          step_ff;
   logic [COUNT_WIDTH-1:0]         rem_ff;
   logic [RESULT_WIDTH-1:0]        quot_ff;
   logic [COUNT_WIDTH-1:0]         divisor_ff;
   logic                           neg_ff;
   logic                           out_valid_ff;
   logic [TIME_WIDTH-1:0]          out_time_ff;
   logic signed [RESULT_WIDTH-1:0] out_value_ff;
   logic                           out_done_ff;

   logic [TIME_WIDTH-1:0]          j_time;
   logic signed [RESULT_WIDTH-1:0] j_value;
   logic [COUNT_WIDTH-1:0]         j_count;
   logic                           j_div;
   logic                           j_done;
   logic                           start_div;
   logic [RESULT_WIDTH-1:0]        magnitude;
   logic [COUNT_WIDTH:0]           shifted;
   logic [COUNT_WIDTH:0]           diff;
   logic                           load;

   assign j_time  = job[JOB_WIDTH-1 -: TIME_WIDTH];
   assign j_value = job[COUNT_WIDTH+2 +: RESULT_WIDTH];
   assign j_count = job[2 +: COUNT_WIDTH];
   assign j_div   = job[1];
   assign j_done  = job[0];

   assign pop       = (state_ff == ST_IDLE) && job_valid && (!out_valid_ff || out_ready);
   assign start_div = pop && j_div && (j_count != '0);
   assign magnitude = j_value[RESULT_WIDTH-1] ? RESULT_WIDTH'(-j_value) : j_value;
   assign load      = (pop && !start_div) || (state_ff == ST_FIN);

   // restoring division, one quotient bit per cycle
   assign shifted = {rem_ff, quot_ff[RESULT_WIDTH-1]};
   assign diff    = shifted - {1'b0, divisor_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start_div) state_in = ST_DIV;
         ST_DIV:  if (step_ff == STEP_LAST) state_in = ST_FIN;
         ST_FIN:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (start_div) begin
            step_ff <= '0;
         end else if (state_ff == ST_DIV) begin
            step_ff <= step_ff + STEP_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_time_ff <= j_time;
         out_done_ff <= j_done;
         if (!start_div) begin
            // an average over no samples reads zero
            out_value_ff <= j_div ? '0 : j_value;
         end
      end
      if (start_div) begin
         rem_ff     <= '0;
         quot_ff    <= magnitude;
         divisor_ff <= j_count;
         neg_ff     <= j_value[RESULT_WIDTH-1];
      end else if (state_ff == ST_DIV) begin
         rem_ff  <= diff[COUNT_WIDTH] ? shifted[COUNT_WIDTH-1:0] : diff[COUNT_WIDTH-1:0];
         quot_ff <= {quot_ff[RESULT_WIDTH-2:0], !diff[COUNT_WIDTH]};
      end
      if (state_ff == ST_FIN) begin
         out_value_ff <= neg_ff ? -$signed(quot_ff) : $signed(quot_ff);
      end
   end

   assign out_valid = out_valid_ff;
   assign out_time  = out_time_ff;
   assign out_value = out_value_ff;
   assign out_done  = out_done_ff;

endmodule

@@ rtl/windowed_time_series_aggregator_unit.sv @@
// path: a result job goes through the job queue, then the output register; averages first run
// the divide and finish states of the bit-serial divider, which holds the back part meanwhile
// throughput: one sample per cycle while the 4-entry job queue has room; a sample that closes
// a window and ends the stream stalls the input until its second job is queued
// reset: method pass-through, interval 0, window closed, queue and output register empty
`timescale 1ns / 1ps
module windowed_time_series_aggregator_unit
   import wtsa_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   wtsa_req_if.sink      req_ch,
   wtsa_rsp_if.source    rsp_ch,
   wtsa_csr_if.sink      csr_ch
);

   localparam int JOB_WIDTH = TIME_WIDTH + RESULT_WIDTH + COUNT_WIDTH + 2;

   logic [METHOD_WIDTH-1:0]   method_ff;
   logic [INTERVAL_WIDTH-1:0] interval_ff;
   cfg_type                   cfg;
   logic                      csr_write;
   logic                      q_push;
   logic [JOB_WIDTH-1:0]      q_push_job;
   logic                      q_full;
   logic                      q_pop;
   logic [JOB_WIDTH-1:0]      q_pop_job;
   logic                      q_valid;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff   <= METHOD_PASS;
         interval_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_ch.index)
            CSR_METHOD:   method_ff   <= csr_ch.data[METHOD_WIDTH-1:0];
            CSR_INTERVAL: interval_ff <= csr_ch.data[INTERVAL_WIDTH-1:0];
            default:      ;
         endcase
      end
   end

   assign cfg.method   = method_ff;
   assign cfg.interval = interval_ff;

   wtsa_front #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH),
      .JOB_WIDTH   (JOB_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_ch.valid),
      .in_ready (req_ch.ready),
      .in_time  (req_ch.sample_time),
      .in_value (req_ch.sample_value),
      .in_last  (req_ch.end_of_stream),
      .push     (q_push),
      .push_job (q_push_job),
      .q_full   (q_full)
   );

   wtsa_fifo #(
      .WIDTH (JOB_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_job),
      .pop_valid (q_valid)
   );

   wtsa_back #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .JOB_WIDTH   (JOB_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job       (q_pop_job),
      .pop       (q_pop),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_time  (rsp_ch.window_time),
      .out_value (rsp_ch.window_value),
      .out_done  (rsp_ch.stream_done)
   );

   // the front never pushes a job into a full queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job pushed into full queue");

   // the back only pops when a job waits
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("job popped from empty queue");

   // a method write lands in the method register
   a_method_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_ch.index == CSR_METHOD) |=>
         method_ff == $past(csr_ch.data[METHOD_WIDTH-1:0]))
      else $error("method register not updated");

endmodule

@@ tb/testbench.sv @@
// self-checking testbench of the windowed time series aggregator unit
`timescale 1ns / 1ps
module testbench;
   import wtsa_pkg::*;

   localparam int     IDLE_PCT    = 29;
   localparam int     SETTLE_CYC  = 80;    // longest result path is the average
   localparam int     PHASES      = 12;
   localparam int     PHASE_ITEMS = 62;
   localparam longint LIMIT_NS    = 64'd12_000_000;

   typedef struct packed {
      logic [TIME_WIDTH-1:0]          stamp;
      logic signed [RESULT_WIDTH-1:0] value;
      logic                           done;
   } window_result_type;

   typedef struct {
      bit                         is_reg;
      logic [CSR_INDEX_WIDTH-1:0] idx;
      logic [CSR_DATA_WIDTH-1:0]  data;
      logic [TIME_WIDTH-1:0]      stamp;
      logic [31:0]                value;
      logic                       eos;
      bit                         typed;
      window_result_type          want;
   } script_row_type;

   logic clock;
   logic reset;
   bit   calm;
   int   mismatches;

   wtsa_req_if #(.VALUE_WIDTH(VALUE_WIDTH_DEFAULT)) req_ch ();
   wtsa_rsp_if                                       rsp_ch ();
   wtsa_csr_if                                       csr_ch ();

   windowed_time_series_aggregator_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("windowed_time_series_aggregator_unit verification failed");
      $finish;
   end

   // ---------------------------------------------------------------- predictor state
   logic [METHOD_WIDTH-1:0]   cfg_method;
   logic [INTERVAL_WIDTH-1:0] cfg_interval;
   bit                        win_open;
   logic [TIME_WIDTH-1:0]     win_start;
   logic signed [63:0]        acc_sum;
   logic [31:0]               acc_count;
   logic signed [31:0]        acc_min;
   logic signed [31:0]        acc_max;

   window_result_type pending_windows[$];
   script_row_type    script[$];

   // typed expectation that rides along with the item on the request channel
   bit                chk_typed;
   window_result_type chk_result;

   function automatic void expect_window(input window_result_type r);
      pending_windows.insert(pending_windows.size(), r);
   endfunction

   function automatic logic signed [63:0] window_aggregate();
      case (cfg_method)
         METHOD_AVG: return (acc_count == 0) ? 64'sd0 : acc_sum / $signed({32'd0, acc_count});
         METHOD_SUM: return acc_sum;
         METHOD_MIN: return {{32{acc_min[31]}}, acc_min};
         default:    return {{32{acc_max[31]}}, acc_max};
      endcase
   endfunction

   function automatic void start_window(input logic [63:0] t, input logic [31:0] raw);
      win_open  = 1'b1;
      win_start = t;
      acc_sum   = {{32{raw[31]}}, raw};
      acc_count = 32'd1;
      acc_min   = raw;
      acc_max   = raw;
   endfunction

   // folds one sample into the window state, queues the windows it closes
   function automatic int fold_sample(input logic [63:0] t, input logic [31:0] raw,
                                      input logic eos);
      logic signed [63:0] v;
      logic signed [64:0] wide;
      int                 n;
      v = {{32{raw[31]}}, raw};
      n = 0;
      if (cfg_method == METHOD_PASS || cfg_method > METHOD_MAX) begin
         expect_window('{t, v, eos});
         if (eos) win_open = 1'b0;
         return 1;
      end
      if (!win_open) begin
         start_window(t, raw);
      end else if (cfg_interval != 0 && (t - win_start) >= {32'd0, cfg_interval}) begin
         expect_window('{win_start, window_aggregate(), 1'b0});
         n++;
         start_window(t, raw);
      end else begin
         wide = $signed({acc_sum[63], acc_sum}) + $signed({v[63], v});
         if (wide[64] != wide[63])
            acc_sum = wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
         else
            acc_sum = wide[63:0];
         if (acc_count != '1) acc_count++;
         if ($signed(raw) < acc_min) acc_min = raw;
         if ($signed(raw) > acc_max) acc_max = raw;
      end
      if (eos) begin
         expect_window('{win_start, window_aggregate(), 1'b1});
         n++;
         win_open = 1'b0;
      end
      return n;
   endfunction

   // ---------------------------------------------------------------- monitor
   window_result_type got;
   window_result_type want;
   int                produced;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.window_time, rsp_ch.window_value, rsp_ch.stream_done};
            if (pending_windows.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: stamp %h value %h done %b",
                           got.stamp, got.value, got.done);
            end else begin
               want = pending_windows.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("result mismatch: expected stamp %h value %h done %b",
                              want.stamp, want.value, want.done);
                     $display("                 got      stamp %h value %h done %b",
                              got.stamp, got.value, got.done);
                  end
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_METHOD:   cfg_method   = csr_ch.data[METHOD_WIDTH-1:0];
               CSR_INTERVAL: cfg_interval = csr_ch.data[INTERVAL_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            produced = fold_sample(req_ch.sample_time, req_ch.sample_value,
                                   req_ch.end_of_stream);
            if (chk_typed) begin
               // the typed row result stands in for the last window it closes
               if (produced > 0) void'(pending_windows.pop_back());
               expect_window(chk_result);
            end
         end
      end
   end

   // ---------------------------------------------------------------- result side stalls
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------- drivers
   task automatic push_sample(input logic [63:0] t, input logic [31:0] v, input logic eos,
                              input bit typed, input window_result_type exp_res);
      @(negedge clock);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.sample_time   <= t;
      req_ch.sample_value  <= v;
      req_ch.end_of_stream <= eos;
      chk_typed            <= typed;
      chk_result           <= exp_res;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // drop valid, wait for all pending windows, then let the back end go quiet
   task automatic drain(input int extra);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_windows.size() != 0) @(negedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- directed table
   function automatic void reg_row(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                   input logic [CSR_DATA_WIDTH-1:0] data);
      script_row_type r;
      r        = '{default: '0};
      r.is_reg = 1'b1;
      r.idx    = idx;
      r.data   = data;
      script.insert(script.size(), r);
   endfunction

   function automatic void smp_row(input logic [63:0] t, input logic [31:0] v, input logic eos);
      script_row_type r;
      r       = '{default: '0};
      r.stamp = t;
      r.value = v;
      r.eos   = eos;
      script.insert(script.size(), r);
   endfunction

   function automatic void chk_row(input logic [63:0] t, input logic [31:0] v, input logic eos,
                                   input logic [63:0] et, input logic [63:0] ev,
                                   input logic ed);
      smp_row(t, v, eos);
      script[$].typed = 1'b1;
      script[$].want  = '{et, ev, ed};
   endfunction

   function automatic void build_script();
      // pass through straight out of reset, value and time extremes
      chk_row(64'd0, 32'h7FFF_FFFF, 1'b0, 64'd0, 64'h0000_0000_7FFF_FFFF, 1'b0);
      chk_row('1, 32'h8000_0000, 1'b1, '1, 64'hFFFF_FFFF_8000_0000, 1'b1);
      // unused method code behaves as pass through
      reg_row(CSR_METHOD, 32'd7);
      chk_row(64'h1234, 32'hFFFF_FFFF, 1'b0, 64'h1234, '1, 1'b0);
      // zero interval sums the whole stream
      reg_row(CSR_METHOD, {29'd0, METHOD_SUM});
      reg_row(CSR_INTERVAL, 32'd0);
      smp_row(64'd10, 32'h7FFF_FFFF, 1'b0);
      chk_row(64'd20, 32'h7FFF_FFFF, 1'b1, 64'd10, 64'h0000_0000_FFFF_FFFE, 1'b1);
      // minimum with a window boundary hit exactly
      reg_row(CSR_METHOD, {29'd0, METHOD_MIN});
      reg_row(CSR_INTERVAL, 32'd100);
      smp_row(64'd1000, 32'd5, 1'b0);
      smp_row(64'd1050, 32'hFFFF_FFFD, 1'b0);
      chk_row(64'd1100, 32'd7, 1'b0, 64'd1000, 64'hFFFF_FFFF_FFFF_FFFD, 1'b0);
      chk_row(64'd1100, 32'd9, 1'b1, 64'd1100, 64'd7, 1'b1);
      // average truncates toward zero, widest interval
      reg_row(CSR_METHOD, {29'd0, METHOD_AVG});
      reg_row(CSR_INTERVAL, 32'hFFFF_FFFF);
      smp_row(64'd0, 32'hFFFF_FFF9, 1'b0);
      chk_row(64'd1, 32'd0, 1'b1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFD, 1'b1);
      // decreasing timestamp closes the window, then close plus flush on one item
      reg_row(CSR_METHOD, {29'd0, METHOD_MAX});
      reg_row(CSR_INTERVAL, 32'd5);
      smp_row(64'd100, 32'd1, 1'b0);
      chk_row(64'd50, 32'd2, 1'b0, 64'd100, 64'd1, 1'b0);
      chk_row(64'd60, 32'd3, 1'b1, 64'd60, 64'd3, 1'b1);
      // open window survives a method change, pass through end of stream drops it
      smp_row(64'd200, 32'd4, 1'b0);
      reg_row(CSR_METHOD, {29'd0, METHOD_PASS});
      chk_row(64'd300, 32'hFFFF_FFF7, 1'b1, 64'd300, 64'hFFFF_FFFF_FFFF_FFF7, 1'b1);
      reg_row(CSR_METHOD, {29'd0, METHOD_MIN});
      chk_row(64'd301, 32'd1, 1'b1, 64'd301, 64'd1, 1'b1);
   endfunction

   // ---------------------------------------------------------------- random helpers
   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'($urandom_range(200)) - 32'd100;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [63:0] pick_base();
      case ($urandom_range(3))
         0:       return 64'd0;
         1:       return 64'hFFFF_FFFF_FFFF_FF00 | 64'($urandom_range(255));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // ---------------------------------------------------------------- main sequence
   initial begin
      logic [63:0]                stamp_now;
      logic [63:0]                step;
      logic [31:0]                span;
      logic [METHOD_WIDTH-1:0]    m;
      logic [INTERVAL_WIDTH-1:0]  phase_interval;
      window_result_type          none;

      none                 = '0;
      mismatches           = 0;
      calm                 = 1'b0;
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.sample_time   = '0;
      req_ch.sample_value  = '0;
      req_ch.end_of_stream = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = '0;
      csr_ch.data          = '0;
      chk_typed            = 1'b0;
      chk_result           = '0;
      cfg_method           = METHOD_PASS;
      cfg_interval         = '0;
      win_open             = 1'b0;
      win_start            = '0;
      acc_sum              = '0;
      acc_count            = '0;
      acc_min              = '0;
      acc_max              = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      build_script();
      foreach (script[i]) begin
         if (script[i].is_reg) begin
            drain(SETTLE_CYC);
            write_reg(script[i].idx, script[i].data);
         end else begin
            push_sample(script[i].stamp, script[i].value, script[i].eos,
                        script[i].typed, script[i].want);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain(SETTLE_CYC);
         calm = (phase == 3);
         m = (phase % 6 < 5) ? METHOD_WIDTH'(phase % 6) : METHOD_WIDTH'(5 + $urandom_range(2));
         case (phase % 5)
            0:       phase_interval = 32'd0;
            1:       phase_interval = 32'd1;
            2:       phase_interval = 32'hFFFF_FFFF;
            3:       phase_interval = 32'($urandom_range(40, 2));
            default: phase_interval = $urandom;
         endcase
         write_reg(CSR_METHOD, ($urandom & ~32'h7) | {29'd0, m});
         write_reg(CSR_INTERVAL, phase_interval);
         span      = (phase_interval == 0) ? 32'd40 : phase_interval / 3 + 32'd1;
         stamp_now = pick_base();
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            logic eos;
            if (phase == 5 && k == PHASE_ITEMS / 2) drain(0);
            case ($urandom_range(19))
               0:       step = 64'd0;
               1:       step = {32'd0, phase_interval};
               2:       step = {32'd0, phase_interval} - 64'd1;
               3:       step = {$urandom, $urandom} - stamp_now;   // noise anywhere
               4:       step = -64'($urandom_range(100, 1));      // going backward
               default: step = 64'($urandom_range(span));
            endcase
            stamp_now = stamp_now + step;
            eos       = ($urandom_range(11) == 0);
            push_sample(stamp_now, pick_value(), eos, 1'b0, none);
            if (eos) stamp_now = pick_base();
         end
      end
      calm = 1'b0;

      drain(SETTLE_CYC + 20);
      if (mismatches == 0)
         $display("windowed_time_series_aggregator_unit verification clean");
      else
         $display("windowed_time_series_aggregator_unit verification failed");
      $finish;
   end

endmodule
